### design/cpcr_pkg.sv
// cpcr_pkg: shared widths, constants and word types for the circle pair collision block
// used by circle_pair_collision_resolve; no dependencies
`timescale 1ns / 1ps

package cpcr_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int POS_W         = 24;
  localparam int RAD_W         = 16;
  localparam int HEAT_W        = 16;
  localparam int RATE_W        = 16;

  localparam logic [HEAT_W-1:0] HEAT_ONE   = 16'd32768;
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd3277;

  // circle data that rides alongside the root and divide pipelines
  typedef struct packed {
    logic signed [POS_W-1:0] fx;
    logic signed [POS_W-1:0] fy;
    logic signed [POS_W-1:0] sx;
    logic signed [POS_W-1:0] sy;
    logic [HEAT_W-1:0]       fh;
    logic [HEAT_W-1:0]       sh;
    logic                    touch;
    logic                    zero;
    logic                    neg_x;
    logic                    neg_y;
  } carry_t;

  // one result word
  typedef struct packed {
    logic signed [POS_W-1:0] new_first_x;
    logic signed [POS_W-1:0] new_first_y;
    logic [HEAT_W-1:0]       new_first_heat;
    logic signed [POS_W-1:0] new_second_x;
    logic signed [POS_W-1:0] new_second_y;
    logic [HEAT_W-1:0]       new_second_heat;
    logic                    in_contact;
  } res_t;

endpackage

### design/cpcr_isqrt.sv
// cpcr_isqrt: pipelined integer square root, one root bit per register stage
// stand-alone; side data is delayed alongside the root
`timescale 1ns / 1ps

module cpcr_isqrt #(
  parameter int RW     = 17,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [2*RW-1:0]   n_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic [RW-1:0]     root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int NW = 2 * RW;

  logic [NW-1:0]     rem_q  [RW];
  logic [RW-1:0]     root_q [RW];
  logic [SIDE_W-1:0] side_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [NW-1:0]     rem_in;
    logic [RW-1:0]     root_in;
    logic [SIDE_W-1:0] side_in;
    logic [NW-1:0]     trial;

    if (k == 0) begin : g_first
      assign rem_in  = n_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    // (2r + 2^b) * 2^b
    assign trial = (NW'(root_in) << (B + 1)) | (NW'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        if (rem_in >= trial) begin
          rem_q[k]  <= rem_in - trial;
          root_q[k] <= root_in | (RW'(1) << B);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[RW-1];
  assign side_o = side_q[RW-1];

endmodule

### design/cpcr_div.sv
// cpcr_div: pipelined restoring divider, two numerators over one divisor, one bit per stage
// stand-alone; quotient must fit in QW bits
`timescale 1ns / 1ps

module cpcr_div #(
  parameter int QW     = 17,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [2*QW:0]     num_x_i,
  input  logic [2*QW:0]     num_y_i,
  input  logic [QW:0]       den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic [QW-1:0]     quo_x_o,
  output logic [QW-1:0]     quo_y_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int NW = 2 * QW + 1;

  logic [NW-1:0]     rx_q   [QW];
  logic [NW-1:0]     ry_q   [QW];
  logic [QW-1:0]     qx_q   [QW];
  logic [QW-1:0]     qy_q   [QW];
  logic [QW:0]       den_q  [QW];
  logic [SIDE_W-1:0] side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [NW-1:0]     rx_in, ry_in, sub;
    logic [QW-1:0]     qx_in, qy_in;
    logic [QW:0]       den_in;
    logic [SIDE_W-1:0] side_in;

    if (k == 0) begin : g_first
      assign rx_in   = num_x_i;
      assign ry_in   = num_y_i;
      assign qx_in   = '0;
      assign qy_in   = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rx_in   = rx_q[k-1];
      assign ry_in   = ry_q[k-1];
      assign qx_in   = qx_q[k-1];
      assign qy_in   = qy_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign sub = NW'(den_in) << B;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
        if (rx_in >= sub) begin
          rx_q[k] <= rx_in - sub;
          qx_q[k] <= qx_in | (QW'(1) << B);
        end else begin
          rx_q[k] <= rx_in;
          qx_q[k] <= qx_in;
        end
        if (ry_in >= sub) begin
          ry_q[k] <= ry_in - sub;
          qy_q[k] <= qy_in | (QW'(1) << B);
        end else begin
          ry_q[k] <= ry_in;
          qy_q[k] <= qy_in;
        end
      end
    end
  end

  assign quo_x_o = qx_q[QW-1];
  assign quo_y_o = qy_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

### design/circle_pair_collision_resolve.sv
// circle_pair_collision_resolve: overlap push and heat exchange for one circle pair per cycle while not stalled
// depends on cpcr_pkg, cpcr_isqrt and cpcr_div
//
//   channel   handshake                  direction  word
//   input     in_valid_i / in_stall_o    in         two circles: centre, radius, heat
//   output    out_valid_o / out_stall_i  out        new centres, new heats, in_contact
//   config    cfg_valid_i / cfg_ready_o  in         heat_transfer_rate, Q0.16
//
// one pair enters per cycle while in_stall_o is low, through bit-per-stage square root and divide
// pipelines of width CW = 17 + max(FRAC_BITS-8, 0)
// rst_ni clears the pipeline, output and skid valid bits, and loads the rate register with 3277
// a stalled output word is held in the output register; one more word lands in a skid
// register, and while that is full in_stall_o is high and the whole pipeline freezes
`timescale 1ns / 1ps

module circle_pair_collision_resolve #(
  parameter int FRAC_BITS = cpcr_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [cpcr_pkg::RATE_W-1:0]           heat_transfer_rate_i,
  // input channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [cpcr_pkg::POS_W-1:0]     first_x_i,
  input  logic signed [cpcr_pkg::POS_W-1:0]     first_y_i,
  input  logic [cpcr_pkg::RAD_W-1:0]            first_radius_i,
  input  logic [cpcr_pkg::HEAT_W-1:0]           first_heat_i,
  input  logic signed [cpcr_pkg::POS_W-1:0]     second_x_i,
  input  logic signed [cpcr_pkg::POS_W-1:0]     second_y_i,
  input  logic [cpcr_pkg::RAD_W-1:0]            second_radius_i,
  input  logic [cpcr_pkg::HEAT_W-1:0]           second_heat_i,
  // output channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [cpcr_pkg::POS_W-1:0]     new_first_x_o,
  output logic signed [cpcr_pkg::POS_W-1:0]     new_first_y_o,
  output logic [cpcr_pkg::HEAT_W-1:0]           new_first_heat_o,
  output logic signed [cpcr_pkg::POS_W-1:0]     new_second_x_o,
  output logic signed [cpcr_pkg::POS_W-1:0]     new_second_y_o,
  output logic [cpcr_pkg::HEAT_W-1:0]           new_second_heat_o,
  output logic                                  in_contact_o
);

  localparam int PW   = cpcr_pkg::POS_W;
  localparam int HW   = cpcr_pkg::HEAT_W;
  localparam int RTW  = cpcr_pkg::RATE_W;
  localparam int SHL  = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
  localparam int SHR  = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
  // aligned radius sum width; on contact the distance and each |d| stay below it
  localparam int CW   = cpcr_pkg::RAD_W + 1 + SHL;
  localparam int SQW  = 2 * CW;
  localparam int D2W  = 2 * PW + 1;
  localparam int CRW  = $bits(cpcr_pkg::carry_t);
  localparam int SSW  = CRW + 3 * CW;
  localparam int LAT  = 5 + 2 * CW;

  // rate register
  logic [RTW-1:0] rate_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= cpcr_pkg::RATE_RESET;
    end else if (cfg_valid_i) begin
      rate_q <= heat_transfer_rate_i;
    end
  end

  // global advance: the pipeline moves whenever the skid register is empty
  logic           sk_vld_q;
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en         = !sk_vld_q;
  assign in_stall_o = sk_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------- stage a
  // absolute deltas, heat saturation, aligned radius sum, hotter heat times rate
  logic [PW-1:0]      adx_a_d, ady_a_d;
  logic [HW-1:0]      fh_a_d, sh_a_d;
  logic [RTW:0]       rsum;
  logic [CW-1:0]      cont_a_d;

  always_comb begin
    adx_a_d  = (first_x_i >= second_x_i) ? PW'(first_x_i - second_x_i)
                                         : PW'(second_x_i - first_x_i);
    ady_a_d  = (first_y_i >= second_y_i) ? PW'(first_y_i - second_y_i)
                                         : PW'(second_y_i - first_y_i);
    fh_a_d   = (first_heat_i > cpcr_pkg::HEAT_ONE) ? cpcr_pkg::HEAT_ONE : first_heat_i;
    sh_a_d   = (second_heat_i > cpcr_pkg::HEAT_ONE) ? cpcr_pkg::HEAT_ONE : second_heat_i;
    rsum     = {1'b0, first_radius_i} + {1'b0, second_radius_i};
    cont_a_d = (CW'(rsum) << SHL) >> SHR;
  end

  logic signed [PW-1:0] fx_a_q, fy_a_q, sx_a_q, sy_a_q;
  logic [PW-1:0]        adx_a_q, ady_a_q;
  logic                 negx_a_q, negy_a_q;
  logic [HW-1:0]        fh_a_q, sh_a_q;
  logic                 hgt_a_q, hlt_a_q;
  logic [CW-1:0]        cont_a_q;
  logic [HW+RTW-1:0]    hprod_a_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      fx_a_q    <= first_x_i;
      fy_a_q    <= first_y_i;
      sx_a_q    <= second_x_i;
      sy_a_q    <= second_y_i;
      adx_a_q   <= adx_a_d;
      ady_a_q   <= ady_a_d;
      negx_a_q  <= first_x_i < second_x_i;
      negy_a_q  <= first_y_i < second_y_i;
      fh_a_q    <= fh_a_d;
      sh_a_q    <= sh_a_d;
      hgt_a_q   <= fh_a_d > sh_a_d;
      hlt_a_q   <= sh_a_d > fh_a_d;
      cont_a_q  <= cont_a_d;
      hprod_a_q <= ((fh_a_d > sh_a_d) ? fh_a_d : sh_a_d) * rate_q;
    end
  end

  // ---------------------------------------------------------------- stage b
  // squares and the rounded heat share
  logic [HW:0]   share;
  logic [HW:0]   gain_f, gain_s;
  logic [HW-1:0] fh_b_d, sh_b_d;

  always_comb begin
    share  = (HW+1)'((hprod_a_q + (HW+RTW)'(32'd32768)) >> RTW);
    gain_f = {1'b0, fh_a_q} + share;
    gain_s = {1'b0, sh_a_q} + share;
    fh_b_d = fh_a_q;
    sh_b_d = sh_a_q;
    if (hgt_a_q) begin
      fh_b_d = HW'({1'b0, fh_a_q} - share);
      sh_b_d = (gain_s > {1'b0, cpcr_pkg::HEAT_ONE}) ? cpcr_pkg::HEAT_ONE : HW'(gain_s);
    end else if (hlt_a_q) begin
      sh_b_d = HW'({1'b0, sh_a_q} - share);
      fh_b_d = (gain_f > {1'b0, cpcr_pkg::HEAT_ONE}) ? cpcr_pkg::HEAT_ONE : HW'(gain_f);
    end
  end

  logic signed [PW-1:0] fx_b_q, fy_b_q, sx_b_q, sy_b_q;
  logic [2*PW-1:0]      sqx_b_q, sqy_b_q;
  logic [SQW-1:0]       c2_b_q;
  logic [CW-1:0]        cont_b_q, magx_b_q, magy_b_q;
  logic                 negx_b_q, negy_b_q;
  logic [HW-1:0]        fh_b_q, sh_b_q, fhn_b_q, shn_b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      fx_b_q   <= fx_a_q;
      fy_b_q   <= fy_a_q;
      sx_b_q   <= sx_a_q;
      sy_b_q   <= sy_a_q;
      sqx_b_q  <= adx_a_q * adx_a_q;
      sqy_b_q  <= ady_a_q * ady_a_q;
      c2_b_q   <= cont_a_q * cont_a_q;
      cont_b_q <= cont_a_q;
      magx_b_q <= CW'(adx_a_q);
      magy_b_q <= CW'(ady_a_q);
      negx_b_q <= negx_a_q;
      negy_b_q <= negy_a_q;
      fh_b_q   <= fh_a_q;
      sh_b_q   <= sh_a_q;
      fhn_b_q  <= fh_b_d;
      shn_b_q  <= sh_b_d;
    end
  end

  // ---------------------------------------------------------------- stage c
  // squared distance, contact test, heat selection
  logic [D2W-1:0]       d2;
  logic                 touch;
  cpcr_pkg::carry_t     carry_c_d;

  always_comb begin
    d2              = D2W'(sqx_b_q) + D2W'(sqy_b_q);
    touch           = d2 < D2W'(c2_b_q);
    carry_c_d.fx    = fx_b_q;
    carry_c_d.fy    = fy_b_q;
    carry_c_d.sx    = sx_b_q;
    carry_c_d.sy    = sy_b_q;
    carry_c_d.fh    = touch ? fhn_b_q : fh_b_q;
    carry_c_d.sh    = touch ? shn_b_q : sh_b_q;
    carry_c_d.touch = touch;
    carry_c_d.zero  = d2 == '0;
    carry_c_d.neg_x = negx_b_q;
    carry_c_d.neg_y = negy_b_q;
  end

  logic [SQW-1:0] n_c_q;
  logic [SSW-1:0] side_c_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      // on contact d2 is below the squared sum, so the low bits hold it all
      n_c_q    <= SQW'(d2);
      side_c_q <= {carry_c_d, cont_b_q, magx_b_q, magy_b_q};
    end
  end

  // ---------------------------------------------------------------- square root
  logic [CW-1:0]  dist_s;
  logic [SSW-1:0] side_s;

  cpcr_isqrt #(
    .RW     (CW),
    .SIDE_W (SSW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .n_i    (n_c_q),
    .side_i (side_c_q),
    .root_o (dist_s),
    .side_o (side_s)
  );

  // ---------------------------------------------------------------- stage d
  // overlap and the two numerator products
  logic [CRW-1:0] carry_s;
  logic [CW-1:0]  cont_s, magx_s, magy_s, ovl_s;

  assign {carry_s, cont_s, magx_s, magy_s} = side_s;
  assign ovl_s = cont_s - dist_s;

  logic [SQW-1:0] px_d_q, py_d_q;
  logic [CW-1:0]  dist_d_q;
  logic [CRW-1:0] carry_d_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_d_q    <= magx_s * ovl_s;
      py_d_q    <= magy_s * ovl_s;
      dist_d_q  <= dist_s;
      carry_d_q <= carry_s;
    end
  end

  // ---------------------------------------------------------------- stage e
  // rounding term and doubled divisor
  logic [SQW:0]   numx_e_q, numy_e_q;
  logic [CW:0]    den_e_q;
  logic [CRW-1:0] carry_e_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      numx_e_q  <= (SQW+1)'(px_d_q) + (SQW+1)'(dist_d_q);
      numy_e_q  <= (SQW+1)'(py_d_q) + (SQW+1)'(dist_d_q);
      den_e_q   <= {dist_d_q, 1'b0};
      carry_e_q <= carry_d_q;
    end
  end

  // ---------------------------------------------------------------- divide
  logic [CW-1:0]  qx_v, qy_v;
  logic [CRW-1:0] carry_v;

  cpcr_div #(
    .QW     (CW),
    .SIDE_W (CRW)
  ) u_div (
    .clk_i   (clk_i),
    .en_i    (en),
    .num_x_i (numx_e_q),
    .num_y_i (numy_e_q),
    .den_i   (den_e_q),
    .side_i  (carry_e_q),
    .quo_x_o (qx_v),
    .quo_y_o (qy_v),
    .side_o  (carry_v)
  );

  // ---------------------------------------------------------------- push and saturate
  function automatic logic signed [PW-1:0] sat_pos(input logic signed [PW+1:0] v);
    logic signed [PW+1:0] hi, lo;
    hi = (PW+2)'(signed'({1'b0, {(PW-1){1'b1}}}));
    lo = -hi - (PW+2)'(1);
    if (v > hi) begin
      sat_pos = PW'(hi);
    end else if (v < lo) begin
      sat_pos = PW'(lo);
    end else begin
      sat_pos = PW'(v);
    end
  endfunction

  cpcr_pkg::carry_t     cv;
  logic signed [PW+1:0] push_x, push_y;
  cpcr_pkg::res_t       fin;

  always_comb begin
    cv     = cpcr_pkg::carry_t'(carry_v);
    push_x = cv.neg_x ? -(PW+2)'(qx_v) : (PW+2)'(qx_v);
    push_y = cv.neg_y ? -(PW+2)'(qy_v) : (PW+2)'(qy_v);
    fin.new_first_x     = cv.fx;
    fin.new_first_y     = cv.fy;
    fin.new_second_x    = cv.sx;
    fin.new_second_y    = cv.sy;
    fin.new_first_heat  = cv.fh;
    fin.new_second_heat = cv.sh;
    fin.in_contact      = cv.touch;
    // coincident centres have no direction, so only heat moves
    if (cv.touch && !cv.zero) begin
      fin.new_first_x  = sat_pos((PW+2)'(cv.fx) + push_x);
      fin.new_first_y  = sat_pos((PW+2)'(cv.fy) + push_y);
      fin.new_second_x = sat_pos((PW+2)'(cv.sx) - push_x);
      fin.new_second_y = sat_pos((PW+2)'(cv.sy) - push_y);
    end
  end

  // ---------------------------------------------------------------- output and skid
  logic           out_vld_q;
  cpcr_pkg::res_t out_q, sk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      sk_vld_q  <= 1'b0;
    end else if (sk_vld_q) begin
      if (!out_stall_i) begin
        sk_vld_q <= 1'b0;
      end
    end else if (!out_vld_q || !out_stall_i) begin
      out_vld_q <= vld_q[LAT-1];
    end else if (vld_q[LAT-1]) begin
      sk_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_vld_q) begin
      if (!out_stall_i) begin
        out_q <= sk_q;
      end
    end else if (!out_vld_q || !out_stall_i) begin
      out_q <= fin;
    end else begin
      sk_q <= fin;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign new_first_x_o     = out_q.new_first_x;
  assign new_first_y_o     = out_q.new_first_y;
  assign new_first_heat_o  = out_q.new_first_heat;
  assign new_second_x_o    = out_q.new_second_x;
  assign new_second_y_o    = out_q.new_second_y;
  assign new_second_heat_o = out_q.new_second_heat;
  assign in_contact_o      = out_q.in_contact;

endmodule
